[rtl/msf_pkg.sv]
`timescale 1ns / 1ps

package msf_pkg;

	// Default sizing of the grid and of the height word
	localparam int unsigned MSF_MAX_COLUMNS = 256;
	localparam int unsigned MSF_MAX_ROWS    = 256;
	localparam int unsigned MSF_HEIGHT_BITS = 16;

	// Configuration port
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned SIZE_CFG_W  = 9;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MATCH_HEIGHT = 2'd0,
		REG_GRID_ROWS    = 2'd1,
		REG_GRID_COLUMNS = 2'd2
	} msf_reg_t;

	localparam logic [SIZE_CFG_W-1:0] GRID_SIZE_RESET = 9'd256;

	// Result fields as they go out on the master side
	localparam int unsigned COORD_W       = 8;
	localparam int unsigned SIDE_OUT_W    = 9;
	localparam int unsigned RESULT_W      = 1 + 4 * COORD_W + SIDE_OUT_W;
	localparam int unsigned OUT_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

	typedef struct packed {
		logic [SIDE_OUT_W-1:0] side_length;
		logic [COORD_W-1:0]    right_column;
		logic [COORD_W-1:0]    bottom_row;
		logic [COORD_W-1:0]    left_column;
		logic [COORD_W-1:0]    top_row;
		logic                  found;
	} msf_result_t;

endpackage

[rtl/msf_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module msf_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/max_uniform_square_finder.sv]
`timescale 1ns / 1ps

// Largest uniform square finder.
// Cell heights enter on the slave stream (s_axis_*) in raster order, one cell
// per request. Each cell whose height equals match_height extends the squares
// of its left, upper and upper-left neighbors; the side of the largest square
// is tracked, first one in raster order wins. After the last cell of a
// grid_rows x grid_columns grid, one result goes out on the master stream.
// Configuration: cfg_we/cfg_index/cfg_data; the user must see that they are
// written only while the block is idle, which the block does not enforce.
// Throughput: one cell per clock while s_axis_tready is high, set by the
// single line-buffer RAM (one read, one write each cycle, with a bypass for
// one-column grids). Result path: cell stage, result stage, output reg.
// Stall: two results can be buffered; s_axis_tready drops only while the last
// cell of a grid waits for room in the result stage.
// Reset: counters, neighbor and best-square registers return to zero and the
// next cell starts a new grid; the line buffer is not cleared (row 0 never
// reads it), so there is no clearing pass.
module max_uniform_square_finder #(
	parameter int unsigned MAX_COLUMNS = msf_pkg::MSF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = msf_pkg::MSF_MAX_ROWS,
	parameter int unsigned HEIGHT_BITS = msf_pkg::MSF_HEIGHT_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [msf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [msf_pkg::CFG_DATA_W-1:0]        cfg_data,
	// cell stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((HEIGHT_BITS+7)/8)*8-1:0]      s_axis_tdata,  // cell_height
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// found, top_row, left_column, bottom_row, right_column, side_length, zero pad
	output logic [msf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

	localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned SIDE_CAP = (MAX_ROWS < MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
	localparam int unsigned SW = $clog2(SIDE_CAP + 1);
	localparam int unsigned NW0 = ($clog2(MAX_COLUMNS + 1) > $clog2(MAX_ROWS + 1)) ?
		$clog2(MAX_COLUMNS + 1) : $clog2(MAX_ROWS + 1);
	localparam int unsigned NW = (NW0 > msf_pkg::SIZE_CFG_W) ? NW0 : msf_pkg::SIZE_CFG_W;
	localparam int unsigned TW0 = (RW > CW) ? RW : CW;
	localparam int unsigned TW = ((TW0 > SW) ? TW0 : SW) + 1;

	// configuration registers
	logic [msf_pkg::CFG_DATA_W-1:0] match_height_q;
	logic [msf_pkg::SIZE_CFG_W-1:0] grid_rows_q;
	logic [msf_pkg::SIZE_CFG_W-1:0] grid_columns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_height_q <= '0;
			grid_rows_q    <= msf_pkg::GRID_SIZE_RESET;
			grid_columns_q <= msf_pkg::GRID_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (msf_pkg::msf_reg_t'(cfg_index))
				msf_pkg::REG_MATCH_HEIGHT: match_height_q <= cfg_data;
				msf_pkg::REG_GRID_ROWS:    grid_rows_q    <= cfg_data[msf_pkg::SIZE_CFG_W-1:0];
				msf_pkg::REG_GRID_COLUMNS: grid_columns_q <= cfg_data[msf_pkg::SIZE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size: zero counts as one, clipped at the maximum
	logic [NW-1:0] rows_ext, cols_ext, rows_eff, cols_eff;
	always_comb begin
		rows_ext = NW'(grid_rows_q);
		cols_ext = NW'(grid_columns_q);
		if (rows_ext == '0) rows_eff = NW'(1);
		else if (rows_ext > NW'(MAX_ROWS)) rows_eff = NW'(MAX_ROWS);
		else rows_eff = rows_ext;
		if (cols_ext == '0) cols_eff = NW'(1);
		else if (cols_ext > NW'(MAX_COLUMNS)) cols_eff = NW'(MAX_COLUMNS);
		else cols_eff = cols_ext;
	end

	// handshake between stages
	logic s1_valid_s1, s1_last_s1, s2_valid_s2, out_valid_q;
	logic s2_adv, s2_room, s1_go, s1_fire, accept;

	assign s2_adv        = s2_valid_s2 && (!out_valid_q || m_axis_tready);
	assign s2_room       = !s2_valid_s2 || s2_adv;
	assign s1_go         = !s1_valid_s1 || !s1_last_s1 || s2_room;
	assign s1_fire       = s1_valid_s1 && s1_go;
	assign s_axis_tready = s1_go;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// raster position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_end, row_end;

	assign col_end = (NW'(col_q) + NW'(1)) >= cols_eff;
	assign row_end = (NW'(row_q) + NW'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : RW'(row_q + RW'(1));
			end else begin
				col_q <= CW'(col_q + CW'(1));
			end
		end
	end

	// line buffer of the previous row's sides
	logic [SW-1:0] side;
	logic [SW-1:0] above_rd;
	logic [CW-1:0] col_s1;

	msf_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_COLUMNS)
	) u_line_buf (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(col_s1),
		.wdata(side),
		.re   (accept),
		.raddr(col_q),
		.rdata(above_rd)
	);

	// cell stage registers
	logic [HEIGHT_BITS-1:0] height_s1;
	logic [RW-1:0]          row_s1;
	logic                   byp_s1;
	logic [SW-1:0]          byp_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s1_last_s1  <= 1'b0;
		end else if (s1_go) begin
			s1_valid_s1 <= accept;
			s1_last_s1  <= accept && col_end && row_end;
		end
	end

	// payload; the bypass covers a read of the column written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			height_s1   <= s_axis_tdata[HEIGHT_BITS-1:0];
			col_s1      <= col_q;
			row_s1      <= row_q;
			byp_s1      <= s1_fire && (col_s1 == col_q);
			byp_data_s1 <= side;
		end
	end

	// square side at this cell
	logic [HEIGHT_BITS+msf_pkg::CFG_DATA_W-1:0] match_wide;
	logic [HEIGHT_BITS-1:0] match_cmp;
	logic [SW-1:0] left_q, diag_q, up, diag, left, min_lu, min_all;
	logic          is_match;

	always_comb begin
		match_wide = {HEIGHT_BITS'(0), match_height_q};
		match_cmp  = match_wide[HEIGHT_BITS-1:0];
		is_match   = (height_s1 == match_cmp);
		up   = (row_s1 == '0) ? '0 : (byp_s1 ? byp_data_s1 : above_rd);
		diag = ((row_s1 == '0) || (col_s1 == '0)) ? '0 : diag_q;
		left = (col_s1 == '0) ? '0 : left_q;
		min_lu  = (up < left) ? up : left;
		min_all = (diag < min_lu) ? diag : min_lu;
		side    = is_match ? SW'(min_all + SW'(1)) : '0;
	end

	// best square so far, handed to the result stage at the end of a grid
	logic [SW-1:0] best_side_q, best_side_nx;
	logic [RW-1:0] best_row_q, best_row_nx;
	logic [CW-1:0] best_col_q, best_col_nx;

	always_comb begin
		if (side > best_side_q) begin
			best_side_nx = side;
			best_row_nx  = row_s1;
			best_col_nx  = col_s1;
		end else begin
			best_side_nx = best_side_q;
			best_row_nx  = best_row_q;
			best_col_nx  = best_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (s1_fire) begin
			left_q <= side;
			diag_q <= up;
			if (s1_last_s1) begin
				best_side_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_side_q <= best_side_nx;
				best_row_q  <= best_row_nx;
				best_col_q  <= best_col_nx;
			end
		end
	end

	// result stage
	logic [SW-1:0] fin_side_s2;
	logic [RW-1:0] fin_row_s2;
	logic [CW-1:0] fin_col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s1_fire && s1_last_s1) begin
			s2_valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			s2_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_last_s1) begin
			fin_side_s2 <= best_side_nx;
			fin_row_s2  <= best_row_nx;
			fin_col_s2  <= best_col_nx;
		end
	end

	// corners from the lower right cell and the side
	msf_pkg::msf_result_t res, res_q;
	logic [TW-1:0] top_w, left_w;
	logic          hit;

	always_comb begin
		hit    = (fin_side_s2 != '0);
		top_w  = TW'(fin_row_s2) + TW'(1) - TW'(fin_side_s2);
		left_w = TW'(fin_col_s2) + TW'(1) - TW'(fin_side_s2);
		res.found        = hit;
		res.top_row      = hit ? msf_pkg::COORD_W'(top_w) : '0;
		res.left_column  = hit ? msf_pkg::COORD_W'(left_w) : '0;
		res.bottom_row   = hit ? msf_pkg::COORD_W'(fin_row_s2) : '0;
		res.right_column = hit ? msf_pkg::COORD_W'(fin_col_s2) : '0;
		res.side_length  = msf_pkg::SIDE_OUT_W'(fin_side_s2);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = msf_pkg::OUT_TDATA_W'(res_q);

endmodule

[tb/sv/max_uniform_square_finder_checker.sv]
`timescale 1ns / 1ps

// Passive checker for the uniform square finder. It tracks configuration
// writes, runs its own side-length recurrence on every accepted cell, queues
// the square expected at the end of each grid and compares each accepted
// result against the oldest queued square.
module max_uniform_square_finder_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [msf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [msf_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  s_axis_tvalid,
	input  logic                                  s_axis_tready,
	input  logic [15:0]                           s_axis_tdata,  // cell_height
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// found, top_row, left_column, bottom_row, right_column, side_length, zero pad
	input  logic [msf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	output int                                    mismatch_count,
	output int                                    squares_outstanding
);

	localparam int unsigned CELL_W = msf_pkg::MSF_HEIGHT_BITS;

	// configuration copy
	logic [CELL_W-1:0]              target_height;
	logic [msf_pkg::SIZE_CFG_W-1:0] rows_setting;
	logic [msf_pkg::SIZE_CFG_W-1:0] columns_setting;

	// recurrence state
	logic [8:0] side_line [msf_pkg::MSF_MAX_COLUMNS];
	logic [8:0] left_run;
	logic [8:0] diag_run;
	logic [7:0] cur_row;
	logic [7:0] cur_col;
	logic [8:0] best_run;
	logic [7:0] best_row_idx;
	logic [7:0] best_col_idx;

	msf_pkg::msf_result_t square_q [$];

	// zero counts as one, anything past the maximum as the maximum
	function automatic logic [8:0] effective_size(input logic [8:0] setting,
			input int unsigned limit);
		if (setting == 9'd0)
			return 9'd1;
		if (setting > limit)
			return 9'(limit);
		return setting;
	endfunction

	task automatic restart_grid();
		left_run     = '0;
		diag_run     = '0;
		cur_row      = '0;
		cur_col      = '0;
		best_run     = '0;
		best_row_idx = '0;
		best_col_idx = '0;
	endtask

	// one cell through the recurrence; queues a square when the grid closes
	task automatic absorb_cell(input logic [CELL_W-1:0] height);
		logic [8:0] rows_eff;
		logic [8:0] cols_eff;
		logic [8:0] up;
		logic [8:0] diag;
		logic [8:0] left;
		logic [8:0] shortest;
		logic [8:0] side;
		msf_pkg::msf_result_t sq;
		rows_eff = effective_size(rows_setting, msf_pkg::MSF_MAX_ROWS);
		cols_eff = effective_size(columns_setting, msf_pkg::MSF_MAX_COLUMNS);
		// missing neighbors on row 0 / column 0 read as zero
		up   = (cur_row == 8'd0) ? 9'd0 : side_line[cur_col];
		diag = (cur_row == 8'd0 || cur_col == 8'd0) ? 9'd0 : diag_run;
		left = (cur_col == 8'd0) ? 9'd0 : left_run;
		if (height == target_height) begin
			shortest = left;
			if (up < shortest)
				shortest = up;
			if (diag < shortest)
				shortest = diag;
			side = shortest + 9'd1;
		end else begin
			side = 9'd0;
		end
		// strict compare: first maximum in raster order wins
		if (side > best_run) begin
			best_run     = side;
			best_row_idx = cur_row;
			best_col_idx = cur_col;
		end
		diag_run          = up;
		left_run          = side;
		side_line[cur_col] = side;
		if ({1'b0, cur_col} + 9'd1 >= cols_eff) begin
			cur_col = 8'd0;
			if ({1'b0, cur_row} + 9'd1 >= rows_eff) begin
				sq = '0;
				if (best_run != 9'd0) begin
					sq.found        = 1'b1;
					sq.top_row      = best_row_idx + 8'd1 - best_run[7:0];
					sq.left_column  = best_col_idx + 8'd1 - best_run[7:0];
					sq.bottom_row   = best_row_idx;
					sq.right_column = best_col_idx;
					sq.side_length  = best_run;
				end
				square_q.push_back(sq);
				restart_grid();
			end else begin
				cur_row = cur_row + 8'd1;
			end
		end else begin
			cur_col = cur_col + 8'd1;
		end
	endtask

	task automatic compare_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_square(input logic [msf_pkg::OUT_TDATA_W-1:0] word);
		msf_pkg::msf_result_t got;
		msf_pkg::msf_result_t want;
		got = word[msf_pkg::RESULT_W-1:0];
		if (square_q.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual %h", $time, word);
			mismatch_count++;
			return;
		end
		want = square_q.pop_front();
		compare_field("found", want.found, got.found);
		compare_field("top_row", want.top_row, got.top_row);
		compare_field("left_column", want.left_column, got.left_column);
		compare_field("bottom_row", want.bottom_row, got.bottom_row);
		compare_field("right_column", want.right_column, got.right_column);
		compare_field("side_length", want.side_length, got.side_length);
		compare_field("tdata pad", '0, word[msf_pkg::OUT_TDATA_W-1:msf_pkg::RESULT_W]);
	endtask

	// sample every request at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_height   = '0;
			rows_setting    = msf_pkg::GRID_SIZE_RESET;
			columns_setting = msf_pkg::GRID_SIZE_RESET;
			for (int i = 0; i < msf_pkg::MSF_MAX_COLUMNS; i++)
				side_line[i] = '0;
			restart_grid();
			square_q.delete();
			mismatch_count = 0;
			squares_outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (msf_pkg::msf_reg_t'(cfg_index))
					msf_pkg::REG_MATCH_HEIGHT: target_height   = cfg_data[CELL_W-1:0];
					msf_pkg::REG_GRID_ROWS:    rows_setting    = cfg_data[8:0];
					msf_pkg::REG_GRID_COLUMNS: columns_setting = cfg_data[8:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_cell(s_axis_tdata[CELL_W-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				check_square(m_axis_tdata);
			squares_outstanding <= square_q.size();
		end
	end

endmodule

[tb/sv/tb_max_uniform_square_finder.sv]
`timescale 1ns / 1ps

module tb_max_uniform_square_finder;

	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_CELLS   = 1900;

	typedef enum int {
		PACE_STEADY,
		PACE_SENDER_GAPS,
		PACE_RECEIVER_STALLS,
		PACE_BOTH
	} pace_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            cfg_we        = 1'b0;
	logic [msf_pkg::CFG_INDEX_W-1:0] cfg_index     = msf_pkg::REG_MATCH_HEIGHT;
	logic [msf_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [15:0]                     s_axis_tdata  = '0;  // cell_height
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// found, top_row, left_column, bottom_row, right_column, side_length, zero pad
	logic [msf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	int mismatch_count;
	int squares_outstanding;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_seq     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int cells_sent   = 0;

	max_uniform_square_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	max_uniform_square_finder_checker checker_inst (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.m_axis_tvalid       (m_axis_tvalid),
		.m_axis_tready       (m_axis_tready),
		.m_axis_tdata        (m_axis_tdata),
		.mismatch_count      (mismatch_count),
		.squares_outstanding (squares_outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random back-pressure, plus one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_seq != hold_seen) begin
			m_axis_tready <= 1'b0;
			hold_seen     <= hold_seq;
			hold_left     <= HOLD_CYCLES;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: too long without any request moving on either stream
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("max_uniform_square_finder verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_STEADY: begin
				idle_pct = 0;
				stall_pct <= 0;
			end
			PACE_SENDER_GAPS: begin
				idle_pct = 56;
				stall_pct <= 0;
			end
			PACE_RECEIVER_STALLS: begin
				idle_pct = 0;
				stall_pct <= 56;
			end
			default: begin
				idle_pct = 30;
				stall_pct <= 30;
			end
		endcase
	endtask

	task automatic write_reg(input msf_pkg::msf_reg_t idx,
			input logic [msf_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one cell, with random gaps ahead of it; returns on the accepting edge
	task automatic send_cell(input logic [15:0] height);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 16'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= height;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		cells_sent++;
	endtask

	// matching cells at hit_pct percent; misses are either random or one bit off
	function automatic logic [15:0] pick_height(input logic [15:0] target, input int hit_pct);
		logic [15:0] miss;
		if ($urandom_range(99) < hit_pct)
			return target;
		if ($urandom_range(1) == 1)
			miss = target ^ (16'd1 << $urandom_range(15));
		else
			miss = 16'($urandom);
		if (miss == target)
			miss = ~target;
		return miss;
	endfunction

	task automatic send_grid(input int cells, input logic [15:0] target);
		int hit_pct;
		case ($urandom_range(4))
			0: hit_pct = 0;
			1: hit_pct = 40;
			2: hit_pct = 75;
			3: hit_pct = 95;
			default: hit_pct = 100;
		endcase
		repeat (cells)
			send_cell(pick_height(target, hit_pct));
	endtask

	// let every expected square come out, then leave the block idle before returning
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (squares_outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int grid_extent(input logic [msf_pkg::CFG_DATA_W-1:0] value);
		if (value[8:0] == 9'd0)
			return 1;
		if (value[8:0] > 9'd256)
			return 256;
		return int'(value[8:0]);
	endfunction

	// size write value: low nine bits carry the size, upper bits are noise
	function automatic logic [msf_pkg::CFG_DATA_W-1:0] size_word(input int size);
		return {7'($urandom), 9'(size)};
	endfunction

	initial begin
		logic [15:0]                    target;
		logic [msf_pkg::CFG_DATA_W-1:0] rows_v;
		logic [msf_pkg::CFG_DATA_W-1:0] cols_v;
		int                             roll;
		int                             phase;
		int                             grids;
		int                             cells;
		int                             random_goal;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: most negative height, full 2x2 square
		set_pace(PACE_STEADY);
		write_reg(msf_pkg::REG_MATCH_HEIGHT, 16'h8000);
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd2);
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'd2);
		repeat (4) send_cell(16'h8000);
		drain_and_settle();

		// most positive height, zero rows taken as one, tie keeps the first square
		write_reg(msf_pkg::REG_MATCH_HEIGHT, 16'h7FFF);
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd0);
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'd3);
		send_cell(16'h7FFF);
		send_cell(16'h7FFE);
		send_cell(16'h7FFF);
		drain_and_settle();

		// columns 0x200 wrap to zero: 1x1 grids, one miss then one hit
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'h0200);
		send_cell(16'h0000);
		send_cell(16'h7FFF);
		drain_and_settle();

		// column count shrinks in the middle of a grid
		write_reg(msf_pkg::REG_MATCH_HEIGHT, 16'd5);
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd3);
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'd3);
		repeat (4) send_cell(16'd5);
		drain_and_settle();
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'd2);
		send_cell(16'd5);
		send_cell(16'd5);
		send_cell(16'd4);
		drain_and_settle();

		// row count shrinks in the middle of a grid
		write_reg(msf_pkg::REG_MATCH_HEIGHT, 16'hFFFB);
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd4);
		repeat (2) send_cell(16'hFFFB);
		drain_and_settle();
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd1);
		send_cell(16'hFFFB);
		send_cell(16'hFFFB);
		drain_and_settle();

		// row count grows in the middle of a grid
		send_cell(16'hFFFB);
		drain_and_settle();
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd2);
		repeat (3) send_cell(16'hFFFB);
		drain_and_settle();

		// long receiver hold-off on 1x1 grids so the result path fills and stalls input
		write_reg(msf_pkg::REG_MATCH_HEIGHT, 16'd0);
		write_reg(msf_pkg::REG_GRID_ROWS, 16'd1);
		write_reg(msf_pkg::REG_GRID_COLUMNS, 16'd1);
		hold_seq <= hold_seq + 1;
		repeat (24) send_cell(pick_height(16'd0, 50));
		drain_and_settle();

		// random phases, pacing rotates through all idling modes
		phase       = 0;
		random_goal = cells_sent + RANDOM_CELLS;
		while (cells_sent < random_goal) begin
			set_pace(pace_t'(phase % 4));
			roll = $urandom_range(9);
			if (roll == 0)
				target = 16'h8000;
			else if (roll == 1)
				target = 16'h7FFF;
			else if (roll == 2)
				target = 16'h0000;
			else if (roll == 3)
				target = 16'hFFFF;
			else
				target = 16'($urandom);
			roll = $urandom_range(99);
			if (roll < 3) begin
				rows_v = size_word($urandom_range(1) == 1 ? 256 : $urandom_range(257, 511));
				cols_v = size_word($urandom_range(1, 2));
			end else if (roll < 6) begin
				rows_v = size_word($urandom_range(1, 2));
				cols_v = size_word($urandom_range(1) == 1 ? 256 : $urandom_range(257, 511));
			end else if (roll < 10) begin
				rows_v = size_word(0);
				cols_v = size_word($urandom_range(0, 8));
			end else begin
				rows_v = size_word($urandom_range(1, 8));
				cols_v = size_word($urandom_range(1, 8));
			end
			write_reg(msf_pkg::REG_MATCH_HEIGHT, target);
			write_reg(msf_pkg::REG_GRID_ROWS, rows_v);
			write_reg(msf_pkg::REG_GRID_COLUMNS, cols_v);
			cells = grid_extent(rows_v) * grid_extent(cols_v);
			grids = (cells > 64) ? 1 : $urandom_range(1, 6);
			repeat (grids) send_grid(cells, target);
			drain_and_settle();
			phase++;
		end

		if (mismatch_count == 0 && squares_outstanding == 0) begin
			$display("max_uniform_square_finder verification clean");
		end else begin
			$display("max_uniform_square_finder verification failed");
		end
		$finish;
	end

endmodule

[max_uniform_square_finder.f]
rtl/msf_pkg.sv
rtl/msf_ram.sv
rtl/max_uniform_square_finder.sv
tb/sv/max_uniform_square_finder_checker.sv
tb/sv/tb_max_uniform_square_finder.sv
